// ----- rtl/u16u8_pkg.sv -----
`default_nettype none

package u16u8_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PATH = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    localparam int unsigned MAX_RES    = 6;  // results one code unit can cause
    localparam int unsigned FIFO_DEPTH = 4;  // default depth of the job queue

    localparam logic [5:0]  SUR_HI_TAG = 6'b110110;  // 0xD800..0xDBFF
    localparam logic [5:0]  SUR_LO_TAG = 6'b110111;  // 0xDC00..0xDFFF
    localparam logic [20:0] CP_PLANE1  = 21'h10000;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  LEAD4      = 8'hF0;
    localparam logic [7:0]  CONT       = 8'h80;
    localparam logic [15:0] LIM1       = 16'h0080;
    localparam logic [15:0] LIM2       = 16'h0800;

    // One decoded request: up to six results; only the final one may be
    // a marker, every earlier one is a data byte.
    typedef struct packed {
        logic [2:0]                 cnt;
        t_kind                      fin_kind;
        logic [MAX_RES-1:0][7:0]    bytes;
    } t_job;

endpackage

`default_nettype wire

// ----- rtl/u16u8_front.sv -----
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [15:0] i_code_unit,
    output t_job             o_job,
    output logic             o_job_vld
);

    logic       r_held_valid, n_held_valid;
    logic [9:0] r_held_bits,  n_held_bits;
    logic       r_at_start,   n_at_start;

    logic              is_zero, is_high, is_low, pair;
    logic [20:0]       cp;
    logic [2:0][7:0]   m;
    logic [1:0]        mn;
    t_kind             fk;
    logic [2:0][7:0]   fl;

    always_comb begin
        is_zero = (i_code_unit == 16'd0);
        is_high = (i_code_unit[15:10] == SUR_HI_TAG);
        is_low  = (i_code_unit[15:10] == SUR_LO_TAG);
        pair    = r_held_valid && is_low;
        cp      = CP_PLANE1 + {1'b0, r_held_bits, i_code_unit[9:0]};

        // held high surrogate flushed alone: 0xED, 0xA0|hb[9:6], 0x80|hb[5:0]
        fl[0] = LEAD3 | 8'h0D;
        fl[1] = CONT | {2'b10, r_held_bits[9:6], 2'b00} >> 2;
        fl[2] = CONT | {2'b00, r_held_bits[5:0]};

        m  = '0;
        mn = 2'd0;
        fk = KIND_DATA;
        if (is_zero) begin
            mn = 2'd1;
            fk = r_at_start ? KIND_END : KIND_PATH;
        end else if (is_high) begin
            mn = 2'd0;
        end else if (i_code_unit < LIM1) begin
            m[0] = {1'b0, i_code_unit[6:0]};
            mn   = 2'd1;
        end else if (i_code_unit < LIM2) begin
            m[0] = LEAD2 | {3'b000, i_code_unit[10:6]};
            m[1] = CONT | {2'b00, i_code_unit[5:0]};
            mn   = 2'd2;
        end else begin
            m[0] = LEAD3 | {4'b0000, i_code_unit[15:12]};
            m[1] = CONT | {2'b00, i_code_unit[11:6]};
            m[2] = CONT | {2'b00, i_code_unit[5:0]};
            mn   = 2'd3;
        end

        o_job = '0;
        if (pair) begin
            o_job.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            o_job.bytes[1] = CONT | {2'b00, cp[17:12]};
            o_job.bytes[2] = CONT | {2'b00, cp[11:6]};
            o_job.bytes[3] = CONT | {2'b00, cp[5:0]};
            o_job.cnt      = 3'd4;
            o_job.fin_kind = KIND_DATA;
        end else if (r_held_valid) begin
            o_job.bytes[0] = fl[0];
            o_job.bytes[1] = fl[1];
            o_job.bytes[2] = fl[2];
            o_job.bytes[3] = m[0];
            o_job.bytes[4] = m[1];
            o_job.bytes[5] = m[2];
            o_job.cnt      = 3'd3 + {1'b0, mn};
            o_job.fin_kind = fk;
        end else begin
            o_job.bytes[0] = m[0];
            o_job.bytes[1] = m[1];
            o_job.bytes[2] = m[2];
            o_job.cnt      = {1'b0, mn};
            o_job.fin_kind = fk;
        end
        o_job_vld = i_accept && (o_job.cnt != 3'd0);

        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        n_at_start   = r_at_start;
        if (i_accept) begin
            n_held_valid = !pair && is_high;
            n_held_bits  = (!pair && is_high) ? i_code_unit[9:0] : 10'd0;
            // a flushed surrogate already cleared path start when it was held
            n_at_start   = !pair && is_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= 10'd0;
            r_at_start   <= 1'b1;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
            r_at_start   <= n_at_start;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u16u8_fifo.sv -----
`default_nettype none

module u16u8_fifo
    import u16u8_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_wr_job,
    input  wire logic i_rd,
    output t_job      o_head,
    output logic      o_empty,
    output logic      o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rp];

    always_comb begin
        wr_en = i_wr && !o_full;
        rd_en = i_rd && !o_empty;
        n_wp  = r_wp;
        n_rp  = r_rp;
        if (wr_en) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? AW'(0) : r_wp + AW'(1);
        end
        if (rd_en) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? AW'(0) : r_rp + AW'(1);
        end
        n_cnt = r_cnt + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u16u8_back.sv -----
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_head,
    input  wire logic       i_head_empty,
    output logic            o_head_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic            o_last
);

    logic [2:0] r_idx, n_idx;
    logic       r_vld, n_vld;
    logic [7:0] r_byte;
    t_kind      r_kind;
    logic       r_last;
    logic       load, is_last;

    always_comb begin
        load       = !i_head_empty && (!r_vld || i_pop);
        is_last    = (r_idx == 3'(i_head.cnt - 3'd1));
        o_head_pop = load && is_last;
        n_idx      = r_idx;
        if (load) begin
            n_idx = is_last ? 3'd0 : r_idx + 3'd1;
        end
        n_vld = load ? 1'b1 : (i_pop ? 1'b0 : r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_vld <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_kind <= is_last ? i_head.fin_kind : KIND_DATA;
            r_last <= is_last;
        end
    end

    assign o_empty    = !r_vld;
    assign o_out_byte = r_byte;
    assign o_kind     = r_kind;
    assign o_last     = r_last;

endmodule

`default_nettype wire

// ----- rtl/utf16_to_utf8_path_list_transcoder_top.sv -----
// Path: a result goes through the job queue, then the registered output stage.
// Throughput: one code unit per cycle into the job queue while not full; one result
//   per cycle out while popped, so the output serialiser sets the sustained rate.
// Reset: synchronous, active low; clears held surrogate, sets start of list, empties
//   the queue and the output register.
`default_nettype none

module utf16_to_utf8_path_list_transcoder_top
    import u16u8_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic             o_last
);

    // Front end: decodes each unit against the held surrogate and path state
    // into a job of up to six results. A high surrogate with nothing held
    // makes no job and is simply absorbed.
    t_job job, head;
    logic job_vld, head_pop, head_empty;
    logic accept;

    assign accept = i_push && !o_full;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_unit (i_code_unit),
        .o_job       (job),
        .o_job_vld   (job_vld)
    );

    // Short job queue: decouples decode from byte serialisation, so the
    // front keeps taking units while a long burst drains.
    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_vld),
        .i_wr_job (job),
        .i_rd     (head_pop),
        .o_head   (head),
        .o_empty  (head_empty),
        .o_full   (o_full)
    );

    // Back end: walks the head job one result per cycle, while the output stage is free
    // or popped, into a registered output stage, which reloads in the same cycle it is popped.
    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_pop   (head_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_last       (o_last)
    );

    // A marker is always the final result of its request and carries a zero byte.
    a_marker_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind != KIND_DATA) |-> (o_last && o_out_byte == 8'd0))
        else $error("marker result not last or byte not zero");

    // With the queue full the output stage must already hold a result.
    a_full_has_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty)
        else $error("queue full while output stage idle");

    // Reset leaves both sides empty.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("not empty after reset");

endmodule

`default_nettype wire

// ----- test/tb_utf16_to_utf8_path_list_transcoder_top.sv -----
`default_nettype none

module tb_utf16_to_utf8_path_list_transcoder_top;
    import u16u8_pkg::*;

    // Run length and safety net
    localparam int TOTAL_UNITS  = 410;     // code-unit requests in the whole run
    localparam int CALM_TAIL    = 60;      // final requests sent with no idling
    localparam int CHOKE_AT     = 150;     // request count at which the long stall starts
    localparam int CHOKE_CYCLES = 120;     // length of the long receiver stall
    localparam int DRAIN_CYCLES = 8;       // settle time after the last expected result
    localparam int LIMIT_CYCLES = 400000;  // generous ceiling on the whole run

    // Scoreboard: keeps its own copy of the transcoder state, turns each
    // accepted code unit into the UTF-8 bytes and markers it must produce,
    // and compares every popped result against the oldest of those.
    class transcode_board;
        typedef struct {
            logic [7:0] data;
            t_kind      kind;
            logic       last;
        } t_expect;

        t_expect    awaited[$];
        logic [9:0] held_bits;    // low ten bits of a pending high surrogate
        bit         held;         // a high surrogate is waiting for its partner
        bit         path_fresh;   // nothing seen yet in the current path
        int         errors;

        function new();
            held_bits  = '0;
            held       = 1'b0;
            path_fresh = 1'b1;
            errors     = 0;
        endfunction

        function void add(logic [7:0] data, t_kind kind);
            t_expect entry;
            entry.data = data;
            entry.kind = kind;
            entry.last = 1'b0;
            awaited.insert(awaited.size(), entry);
        endfunction

        // Scalar value to 1..4 UTF-8 bytes
        function void encode(logic [20:0] cp);
            if (cp < 21'(LIM1)) begin
                add(cp[7:0], KIND_DATA);
            end else if (cp < 21'(LIM2)) begin
                add(LEAD2 | {3'b0, cp[10:6]}, KIND_DATA);
                add(CONT | {2'b0, cp[5:0]}, KIND_DATA);
            end else if (cp < CP_PLANE1) begin
                add(LEAD3 | {4'b0, cp[15:12]}, KIND_DATA);
                add(CONT | {2'b0, cp[11:6]}, KIND_DATA);
                add(CONT | {2'b0, cp[5:0]}, KIND_DATA);
            end else begin
                add(LEAD4 | {5'b0, cp[20:18]}, KIND_DATA);
                add(CONT | {2'b0, cp[17:12]}, KIND_DATA);
                add(CONT | {2'b0, cp[11:6]}, KIND_DATA);
                add(CONT | {2'b0, cp[5:0]}, KIND_DATA);
            end
        endfunction

        function void take_unit(logic [15:0] unit);
            int  first;
            bit  paired;
            first  = awaited.size();
            paired = 1'b0;
            if (held) begin
                if (unit[15:10] == SUR_LO_TAG) begin
                    encode(CP_PLANE1 + {1'b0, held_bits, unit[9:0]});
                    path_fresh = 1'b0;
                    paired     = 1'b1;
                end else begin
                    // unpaired high surrogate goes out on its own
                    encode({5'b0, SUR_HI_TAG, held_bits});
                end
                held      = 1'b0;
                held_bits = '0;
            end
            if (!paired) begin
                if (unit == 16'h0000) begin
                    if (path_fresh) begin
                        add(8'h00, KIND_END);
                    end else begin
                        add(8'h00, KIND_PATH);
                        path_fresh = 1'b1;
                    end
                end else if (unit[15:10] == SUR_HI_TAG) begin
                    held_bits  = unit[9:0];
                    held       = 1'b1;
                    path_fresh = 1'b0;
                end else begin
                    encode({5'b0, unit});
                    path_fresh = 1'b0;
                end
            end
            if (awaited.size() > first)
                awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [7:0] data, logic [1:0] kind, logic last);
            t_expect want;
            if (awaited.size() == 0) begin
                $error("result with none pending: out_byte %0h kind %0d last %0d",
                       data, kind, last);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (data !== want.data) begin
                    $error("out_byte: expected %0h, got %0h", want.data, data);
                    errors++;
                end
                if (kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    // DUT connections, all inputs known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_push      = 1'b0;
    logic [15:0] i_code_unit = 16'h0000;
    logic        i_pop       = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic        o_last;

    transcode_board board;

    // Traffic shaping shared between the sender and the receiver
    int units_sent    = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit calm          = 1'b0;   // final stretch: nobody idles
    bit choke_pending = 1'b0;   // sender asks the receiver for its long stall
    bit choked        = 1'b0;

    // Directed opening: list end on an empty list (twice), the edges of each
    // UTF-8 length, both extreme surrogate pairs, a lone low surrogate, a high
    // surrogate displaced by another, a flush followed by a 3-byte unit (six
    // results from one request), a flush by zero ending a path, and a list end.
    logic [15:0] opening_units [24] = '{
        16'h0000, 16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF,
        16'h0800, 16'hFFFF, 16'h0000, 16'hD800, 16'hDC00, 16'hDBFF,
        16'hDFFF, 16'hDC00, 16'hD800, 16'hDBFF, 16'hE000, 16'hDA5A,
        16'h0000, 16'h0000, 16'hDFFF, 16'hD7FF, 16'hAAAA, 16'h0000
    };

    utf16_to_utf8_path_list_transcoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_code_unit (i_code_unit),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Monitor: everything is sampled at the rising edge, before the DUT's
    // own updates land, so request and result handshakes are seen exactly
    // as the DUT sees them.
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full)
            board.take_unit(i_code_unit);
        if (i_rst_n && i_pop && !o_empty)
            board.check_result(o_out_byte, o_kind, o_last);
    end

    function automatic int idle_share();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 30;
        endcase
    endfunction

    // One code-unit request, optionally preceded by an idle burst; returns
    // at the edge where the request is taken.
    task automatic send_unit(input logic [15:0] unit);
        if (!calm && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_code_unit <= unit;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        units_sent++;
    endtask

    // One character of a path: mostly well-formed, with the odd lone surrogate
    task automatic send_symbol();
        case ($urandom_range(0, 9))
            0, 1, 2: send_unit(16'($urandom_range(16'h0001, 16'h007F)));
            3, 4:    send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
            5: begin
                if ($urandom_range(0, 1))
                    send_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
                else
                    send_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
            end
            6, 7: begin
                send_unit(16'hD800 | 16'($urandom_range(0, 16'h03FF)));
                send_unit(16'hDC00 | 16'($urandom_range(0, 16'h03FF)));
            end
            8:       send_unit(16'hDC00 | 16'($urandom_range(0, 16'h03FF)));
            default: send_unit(16'hD800 | 16'($urandom_range(0, 16'h03FF)));
        endcase
    endtask

    task automatic send_path();
        repeat ($urandom_range(1, 8)) send_symbol();
        send_unit(16'h0000);
    endtask

    // Receiver: random pop bursts, plus one long stall on request so that
    // the job queue backs up and full is driven high.
    initial begin
        repeat (4) @(posedge i_clk);
        i_pop <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (choke_pending) begin
                choke_pending = 1'b0;
                i_pop <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge i_clk);
                i_pop <= 1'b1;
            end else if (!calm && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                i_pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_pop <= 1'b1;
            end
        end
    end

    // Main sequence
    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_units[n])
            send_unit(opening_units[n]);

        // Random part: lists of mostly well-formed paths, with short bursts of raw
        // 16-bit noise between them
        while (units_sent < TOTAL_UNITS) begin
            calm        = (units_sent >= TOTAL_UNITS - CALM_TAIL);
            tx_idle_pct = idle_share();
            rx_idle_pct = idle_share();
            if (!choked && units_sent >= CHOKE_AT) begin
                choked        = 1'b1;
                tx_idle_pct   = 0;    // keep requests coming while the output is blocked
                choke_pending = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) send_unit(16'($urandom()));
            end else begin
                repeat ($urandom_range(1, 3)) send_path();
                send_unit(16'h0000);
            end
        end
        i_push <= 1'b0;

        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_fifo.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_path_list_transcoder_top.sv
test/tb_utf16_to_utf8_path_list_transcoder_top.sv
